### rtl/core/kcs_pkg.sv
`timescale 1ns / 1ps

package kcs_pkg;

    // Request codes carried on req_type.
    localparam logic [1:0] REQ_LEDS  = 2'd0;
    localparam logic [1:0] REQ_RATE  = 2'd1;
    localparam logic [1:0] REQ_REPLY = 2'd2;
    localparam logic [1:0] REQ_TICK  = 2'd3;

    // Completion status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FAILED  = 2'd1;
    localparam logic [1:0] ST_SKIPPED = 2'd2;
    localparam logic [1:0] ST_BUSY    = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TIMEOUT     = 2'd0;
    localparam logic [1:0] CFG_RESEND_LIM  = 2'd1;
    localparam logic [1:0] CFG_MAX_OTHER   = 2'd2;

    // Configuration reset values.
    localparam logic [15:0] TIMEOUT_RESET    = 16'd16384;
    localparam logic [3:0]  RESEND_LIM_RESET = 4'd4;
    localparam logic [11:0] MAX_OTHER_RESET  = 12'd4095;

    // Keyboard protocol bytes.
    localparam logic [7:0] KB_ACK     = 8'hFA;
    localparam logic [7:0] KB_RETRY   = 8'hFE;
    localparam logic [7:0] CMD_LEDS   = 8'hED;
    localparam logic [7:0] CMD_RATE   = 8'hF3;
    localparam logic [7:0] CMD_ENABLE = 8'hF4;

    // Typematic delay thresholds in milliseconds.
    localparam logic [15:0] DELAY_T1 = 16'd375;
    localparam logic [15:0] DELAY_T2 = 16'd625;
    localparam logic [15:0] DELAY_T3 = 16'd875;

    // Rate code is floor((rate - 33) * 31 / 467), clamped to 31. From an offset of
    // 482 upward the quotient is already 31 or more. Below that, the product
    // offset * 31 stays under 15000, and multiplying by ceil(2^23 / 467) = 17963
    // and shifting right by 23 gives the exact quotient. 31 * 17963 = 556853.
    localparam logic [15:0] RATE_MIN_MS = 16'd33;
    localparam logic [15:0] RATE_SAT_X  = 16'd482;
    localparam logic [19:0] RATE_RECIP  = 20'd556853;
    localparam logic [4:0]  RATE_MAX    = 5'd31;

endpackage

### rtl/core/kcs_rate_map.sv
`timescale 1ns / 1ps

module kcs_rate_map
    import kcs_pkg::*;
(
    input  logic [15:0] delay_ms,
    input  logic [15:0] rate_ms,
    output logic [7:0]  typematic
);

    logic [1:0]  dcode;
    logic [4:0]  rcode;
    logic [15:0] offset;
    logic [27:0] product;

    always_comb
    begin
        if (delay_ms < DELAY_T1)
        begin
            dcode = 2'd0;
        end
        else if (delay_ms < DELAY_T2)
        begin
            dcode = 2'd1;
        end
        else if (delay_ms < DELAY_T3)
        begin
            dcode = 2'd2;
        end
        else
        begin
            dcode = 2'd3;
        end
    end

    assign offset  = rate_ms - RATE_MIN_MS;
    // The offset is below 482 whenever the product is used, so nine bits suffice.
    assign product = 28'({19'd0, offset[8:0]} * {8'd0, RATE_RECIP});

    always_comb
    begin
        if (rate_ms <= RATE_MIN_MS)
        begin
            rcode = 5'd0;
        end
        else if (offset >= RATE_SAT_X)
        begin
            rcode = RATE_MAX;
        end
        else
        begin
            rcode = product[27:23];
        end
    end

    assign typematic = {1'b0, dcode, rcode};

endmodule

### rtl/core/keyboard_command_sender.sv
`timescale 1ns / 1ps

// Host-side command sequencer for a PS/2 keyboard. Each input transfer is one event:
// a set-LED request, a set-repeat-rate request, a byte received from the keyboard,
// or a timer tick. A request sends its command byte (0xED or 0xF3) and, once the
// keyboard acknowledges it, the data byte; RESEND replies repeat the current byte up
// to resend_limit times, other reply bytes are counted against max_other_bytes, and
// reply_timeout_ticks ticks with no reply fail the byte. A failed byte triggers a
// single 0xF4 recovery byte and then a failed completion; a failed LED request also
// turns off all further commands until reset. Each event yields at most one output
// transfer: a byte to transmit, or a completion with its status. The block takes one
// event per clock while in_stall is low: an input register feeds the update logic (a
// compare chain and one 9x20 multiplier for the rate code) that writes an output
// register. An event passes through the input register and then the output register,
// and the input register lets one more event in while a result waits. Configuration
// writes are always ready and must only be made while no request is running.
module keyboard_command_sender
    import kcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [15:0] shift_flags,
    input  logic [15:0] delay_ms,
    input  logic [15:0] rate_ms,
    input  logic [7:0]  rx_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        done_res,
    output logic [1:0]  status,
    output logic        enabled
);

    typedef enum logic [1:0] {PH_IDLE, PH_CMD, PH_REC} phase_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       done;
        logic [1:0] status;
        logic       enabled;
    } result_t;

    // Configuration registers.
    logic [15:0] timeout_reg;
    logic [3:0]  resend_lim_reg;
    logic [11:0] max_other_reg;

    // Input register.
    logic        in_full_reg;
    logic [1:0]  req_reg;
    logic [2:0]  leds_reg;
    logic [15:0] delay_reg;
    logic [15:0] rate_reg;
    logic [7:0]  rx_reg;

    // Sequencer state.
    phase_t      phase_reg,   phase_next;
    logic        step_reg,    step_next;
    logic [7:0]  cur_reg,     cur_next;
    logic [7:0]  second_reg,  second_next;
    logic [3:0]  attempts_reg, attempts_next;
    logic [11:0] other_reg,   other_next;
    logic [15:0] tick_reg,    tick_next;
    logic        enabled_reg, enabled_next;
    logic        is_led_reg,  is_led_next;

    // Output register.
    logic        out_valid_reg;
    result_t     out_reg;

    logic        advance;
    logic        in_take;
    logic        res_valid;
    result_t     res;
    logic [7:0]  typematic;
    logic        do_fail;
    logic        do_begin;
    logic [7:0]  begin_byte;
    logic        do_finish;
    logic [1:0]  finish_status;
    logic [15:0] tick_inc;
    logic [11:0] other_inc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= TIMEOUT_RESET;
            resend_lim_reg <= RESEND_LIM_RESET;
            max_other_reg  <= MAX_OTHER_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TIMEOUT:    timeout_reg    <= cfg_data;
                CFG_RESEND_LIM: resend_lim_reg <= cfg_data[3:0];
                CFG_MAX_OTHER:  max_other_reg  <= cfg_data[11:0];
                default:        ;
            endcase
        end
    end

    // The held event moves on whenever the output register is free or being emptied.
    assign advance  = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_full_reg && out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_full_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg   <= req_type;
            leds_reg  <= shift_flags[10:8];
            delay_reg <= delay_ms;
            rate_reg  <= rate_ms;
            rx_reg    <= rx_byte;
        end
    end

    kcs_rate_map u_rate_map (
        .delay_ms  (delay_reg),
        .rate_ms   (rate_reg),
        .typematic (typematic)
    );

    assign tick_inc  = tick_reg + 16'd1;
    assign other_inc = other_reg + 12'd1;

    // Event decode. Each branch raises at most one of: start a byte, finish the
    // request, fail the current byte, or a plain resend result.
    always_comb
    begin
        phase_next    = phase_reg;
        step_next     = step_reg;
        cur_next      = cur_reg;
        second_next   = second_reg;
        attempts_next = attempts_reg;
        other_next    = other_reg;
        tick_next     = tick_reg;
        enabled_next  = enabled_reg;
        is_led_next   = is_led_reg;

        res_valid     = 1'b0;
        res           = '0;
        do_fail       = 1'b0;
        do_begin      = 1'b0;
        begin_byte    = CMD_ENABLE;
        do_finish     = 1'b0;
        finish_status = ST_OK;

        case (req_reg)
            REQ_LEDS, REQ_RATE:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    res_valid  = 1'b1;
                    res.done   = 1'b1;
                    res.status = ST_BUSY;
                end
                else if (!enabled_reg)
                begin
                    res_valid  = 1'b1;
                    res.done   = 1'b1;
                    res.status = ST_SKIPPED;
                end
                else
                begin
                    phase_next = PH_CMD;
                    step_next  = 1'b0;
                    do_begin   = 1'b1;
                    if (req_reg == REQ_LEDS)
                    begin
                        is_led_next = 1'b1;
                        second_next = {5'd0, leds_reg};
                        begin_byte  = CMD_LEDS;
                    end
                    else
                    begin
                        is_led_next = 1'b0;
                        second_next = typematic;
                        begin_byte  = CMD_RATE;
                    end
                end
            end
            REQ_TICK:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    tick_next = tick_inc;
                    do_fail   = (tick_inc >= timeout_reg);
                end
            end
            REQ_REPLY:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    tick_next = '0;
                    if (rx_reg == KB_ACK)
                    begin
                        if (phase_reg == PH_CMD && !step_reg)
                        begin
                            step_next  = 1'b1;
                            do_begin   = 1'b1;
                            begin_byte = second_reg;
                        end
                        else if (phase_reg == PH_CMD)
                        begin
                            do_finish = 1'b1;
                        end
                        else
                        begin
                            // Recovery byte acknowledged: the request still failed.
                            do_finish     = 1'b1;
                            finish_status = ST_FAILED;
                            if (is_led_reg)
                            begin
                                enabled_next = 1'b0;
                            end
                        end
                    end
                    else if (rx_reg == KB_RETRY)
                    begin
                        if (attempts_reg == 4'd0)
                        begin
                            do_fail = 1'b1;
                        end
                        else
                        begin
                            attempts_next = attempts_reg - 4'd1;
                            other_next    = '0;
                            res_valid     = 1'b1;
                            res.tx_valid  = 1'b1;
                            res.tx_byte   = cur_reg;
                        end
                    end
                    else
                    begin
                        other_next = other_inc;
                        do_fail    = (other_inc >= max_other_reg);
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (do_fail)
        begin
            if (phase_reg == PH_CMD)
            begin
                phase_next = PH_REC;
                do_begin   = 1'b1;
                begin_byte = CMD_ENABLE;
            end
            else
            begin
                do_finish     = 1'b1;
                finish_status = ST_FAILED;
                if (is_led_reg)
                begin
                    enabled_next = 1'b0;
                end
            end
        end

        if (do_begin)
        begin
            cur_next      = begin_byte;
            attempts_next = resend_lim_reg;
            other_next    = '0;
            tick_next     = '0;
            res_valid     = 1'b1;
            res.tx_valid  = 1'b1;
            res.tx_byte   = begin_byte;
        end

        if (do_finish)
        begin
            phase_next = PH_IDLE;
            step_next  = 1'b0;
            res_valid  = 1'b1;
            res.done   = 1'b1;
            res.status = finish_status;
        end

        res.enabled = enabled_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            step_reg      <= 1'b0;
            cur_reg       <= '0;
            second_reg    <= '0;
            attempts_reg  <= '0;
            other_reg     <= '0;
            tick_reg      <= '0;
            enabled_reg   <= 1'b1;
            is_led_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg    <= phase_next;
                step_reg     <= step_next;
                cur_reg      <= cur_next;
                second_reg   <= second_next;
                attempts_reg <= attempts_next;
                other_reg    <= other_next;
                tick_reg     <= tick_next;
                enabled_reg  <= enabled_next;
                is_led_reg   <= is_led_next;
            end

            if (advance && res_valid)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= res;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign tx_valid  = out_reg.tx_valid;
    assign tx_byte   = out_reg.tx_byte;
    assign done_res  = out_reg.done;
    assign status    = out_reg.status;
    assign enabled   = out_reg.enabled;

    // Once commands are turned off they stay off until reset.
    a_enabled_never_rises: assert property (
        @(posedge clk) disable iff (!rst_n)
        !$rose(enabled_reg)
    ) else $error("commands-enabled flag was set again");

    // A transmitted byte always leaves a request running.
    a_tx_leaves_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        (advance && res_valid && res.tx_valid) |=> (phase_reg != PH_IDLE)
    ) else $error("byte sent while sequencer returned to idle");

    // A request is only skipped while commands are off.
    a_skip_when_disabled: assert property (
        @(posedge clk) disable iff (!rst_n)
        (advance && res_valid && res.done && res.status == ST_SKIPPED) |-> !enabled_reg
    ) else $error("request skipped while commands are enabled");

    // An ok or failed completion returns the sequencer to idle.
    a_finish_goes_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (advance && res_valid && res.done && (res.status == ST_OK || res.status == ST_FAILED))
            |=> (phase_reg == PH_IDLE)
    ) else $error("request completed but sequencer is still busy");

endmodule

### sim/kcs_command_checker.sv
`timescale 1ns / 1ps

// Watches the configuration, event and result channels of the keyboard command
// sender, predicts every result from the accepted events and compares each one.
module kcs_command_checker
    import kcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [15:0] shift_flags,
    input  logic [15:0] delay_ms,
    input  logic [15:0] rate_ms,
    input  logic [7:0]  rx_byte,

    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        tx_valid,
    input  logic [7:0]  tx_byte,
    input  logic        done_res,
    input  logic [1:0]  status,
    input  logic        enabled,

    output int          err_count,
    output int          outstanding,
    output logic        seq_busy,
    output logic        cmds_on
);

    typedef enum logic [1:0] {
        SEQ_IDLE    = 2'd0,
        SEQ_COMMAND = 2'd1,
        SEQ_RECOVER = 2'd2
    } seq_phase_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       done;
        logic [1:0] status;
        logic       enabled;
    } kb_result_t;

    localparam int RATE_STEPS = 31;
    localparam int RATE_SPAN  = 467;

    logic [15:0] timeout_ticks;
    logic [3:0]  resend_lim;
    logic [11:0] other_lim;

    seq_phase_t  phase;
    logic        second_sent;
    logic [7:0]  cur_byte;
    logic [7:0]  data_byte;
    int          attempts_left;
    int          other_cnt;
    int          tick_cnt;
    logic        cmds_enabled;
    logic        led_request;

    kb_result_t  pending_results[$];

    function automatic kb_result_t make_result(input logic txv, input logic [7:0] b,
                                               input logic dn, input logic [1:0] st);
        kb_result_t r;
        r.tx_valid = txv;
        r.tx_byte  = b;
        r.done     = dn;
        r.status   = st;
        r.enabled  = cmds_enabled;
        return r;
    endfunction

    function automatic logic [7:0] typematic_byte(input logic [15:0] dly,
                                                  input logic [15:0] rte);
        logic [1:0] delay_code;
        int         rate_code;
        if (dly < DELAY_T1)
            delay_code = 2'd0;
        else if (dly < DELAY_T2)
            delay_code = 2'd1;
        else if (dly < DELAY_T3)
            delay_code = 2'd2;
        else
            delay_code = 2'd3;
        if (rte <= RATE_MIN_MS)
            rate_code = 0;
        else
            rate_code = (int'(rte - RATE_MIN_MS) * RATE_STEPS) / RATE_SPAN;
        if (rate_code > int'(RATE_MAX))
            rate_code = int'(RATE_MAX);
        return {1'b0, delay_code, rate_code[4:0]};
    endfunction

    function automatic kb_result_t start_byte(input logic [7:0] b);
        cur_byte      = b;
        attempts_left = int'(resend_lim);
        other_cnt     = 0;
        tick_cnt      = 0;
        return make_result(1'b1, b, 1'b0, ST_OK);
    endfunction

    function automatic kb_result_t close_request(input logic [1:0] st);
        phase       = SEQ_IDLE;
        second_sent = 1'b0;
        return make_result(1'b0, 8'h00, 1'b1, st);
    endfunction

    // A failed command byte moves on to the enable byte; a failed enable byte
    // ends the request, and for an LED request it turns commands off for good.
    function automatic kb_result_t byte_failed();
        if (phase == SEQ_COMMAND)
        begin
            phase = SEQ_RECOVER;
            return start_byte(CMD_ENABLE);
        end
        if (led_request)
            cmds_enabled = 1'b0;
        return close_request(ST_FAILED);
    endfunction

    function automatic bit next_command_result(input logic [1:0] kind,
                                               input logic [15:0] flags,
                                               input logic [15:0] dly,
                                               input logic [15:0] rte,
                                               input logic [7:0] rx,
                                               output kb_result_t res);
        res = '0;
        if (kind == REQ_LEDS || kind == REQ_RATE)
        begin
            if (phase != SEQ_IDLE)
            begin
                res = make_result(1'b0, 8'h00, 1'b1, ST_BUSY);
                return 1'b1;
            end
            if (!cmds_enabled)
            begin
                res = make_result(1'b0, 8'h00, 1'b1, ST_SKIPPED);
                return 1'b1;
            end
            phase       = SEQ_COMMAND;
            second_sent = 1'b0;
            led_request = (kind == REQ_LEDS);
            data_byte   = led_request ? {5'b0, flags[10:8]} : typematic_byte(dly, rte);
            res = start_byte(led_request ? CMD_LEDS : CMD_RATE);
            return 1'b1;
        end
        if (phase == SEQ_IDLE)
            return 1'b0;
        if (kind == REQ_TICK)
        begin
            tick_cnt++;
            if (tick_cnt >= int'(timeout_ticks))
            begin
                res = byte_failed();
                return 1'b1;
            end
            return 1'b0;
        end
        tick_cnt = 0;
        if (rx == KB_ACK)
        begin
            if (phase == SEQ_COMMAND && !second_sent)
            begin
                second_sent = 1'b1;
                res = start_byte(data_byte);
            end
            else if (phase == SEQ_COMMAND)
                res = close_request(ST_OK);
            else
            begin
                if (led_request)
                    cmds_enabled = 1'b0;
                res = close_request(ST_FAILED);
            end
            return 1'b1;
        end
        if (rx == KB_RETRY)
        begin
            if (attempts_left == 0)
                res = byte_failed();
            else
            begin
                attempts_left--;
                other_cnt = 0;
                res = make_result(1'b1, cur_byte, 1'b0, ST_OK);
            end
            return 1'b1;
        end
        other_cnt++;
        if (other_cnt >= int'(other_lim))
        begin
            res = byte_failed();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d (0x%0h), actual %0d (0x%0h)", name, want, want, got, got);
            err_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        kb_result_t want;
        if (!rst_n)
        begin
            timeout_ticks = TIMEOUT_RESET;
            resend_lim    = RESEND_LIM_RESET;
            other_lim     = MAX_OTHER_RESET;
            phase         = SEQ_IDLE;
            second_sent   = 1'b0;
            cur_byte      = 8'h00;
            data_byte     = 8'h00;
            attempts_left = 0;
            other_cnt     = 0;
            tick_cnt      = 0;
            cmds_enabled  = 1'b1;
            led_request   = 1'b0;
            err_count     = 0;
            pending_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TIMEOUT:    timeout_ticks = cfg_data;
                    CFG_RESEND_LIM: resend_lim    = cfg_data[3:0];
                    CFG_MAX_OTHER:  other_lim     = cfg_data[11:0];
                    default:        ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: tx %0d 0x%02h done %0d status %0d enabled %0d",
                           tx_valid, tx_byte, done_res, status, enabled);
                    err_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("tx_valid", int'(want.tx_valid), int'(tx_valid));
                    compare_field("tx_byte", int'(want.tx_byte), int'(tx_byte));
                    compare_field("done_res", int'(want.done), int'(done_res));
                    compare_field("status", int'(want.status), int'(status));
                    compare_field("enabled", int'(want.enabled), int'(enabled));
                end
            end
            if (in_valid && !in_stall)
            begin
                if (next_command_result(req_type, shift_flags, delay_ms, rate_ms, rx_byte, want))
                    pending_results.push_back(want);
            end
        end
        outstanding = pending_results.size();
        seq_busy    = (phase != SEQ_IDLE);
        cmds_on     = cmds_enabled;
    end

endmodule

### sim/keyboard_command_sender_tb.sv
`timescale 1ns / 1ps

// Top of the keyboard command sender bench. This module only makes stimulus and
// gives the verdict; every result is predicted and checked by kcs_command_checker.
module keyboard_command_sender_tb;
    import kcs_pkg::*;

    // Cycles with no transfer on any channel before the run is declared hung.
    // The longest quiet stretch in a correct run is the deliberate receiver hold.
    localparam int QUIET_LIMIT = 5000;
    localparam int LONG_HOLD   = 300;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;

    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index   = CFG_TIMEOUT;
    logic [15:0] cfg_data    = 16'h0000;

    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type    = REQ_TICK;
    logic [15:0] shift_flags = 16'h0000;
    logic [15:0] delay_ms    = 16'h0000;
    logic [15:0] rate_ms     = 16'h0000;
    logic [7:0]  rx_byte     = 8'h00;

    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        done_res;
    logic [1:0]  status;
    logic        enabled;

    int          err_count;
    int          outstanding;
    logic        chk_busy;
    logic        chk_cmds_on;

    // Idle rates of the two sides, in percent of cycles.
    int          send_idle_pct = 19;
    int          recv_idle_pct = 82;

    // The stimulus asks for a long receiver hold by bumping hold_epoch; the
    // receiver process counts the hold out on its own.
    int          hold_epoch = 0;
    int          hold_seen  = 0;
    int          hold_left  = 0;

    // Number of events that the block acted on; ignored events are not counted.
    int          item_count = 0;
    int          quiet_cycles = 0;

    // Our own copy of the register settings, used to keep well-formed reply
    // sequences from failing.
    int          cur_timeout = int'(TIMEOUT_RESET);
    int          cur_resend  = int'(RESEND_LIM_RESET);
    int          cur_other   = int'(MAX_OTHER_RESET);

    keyboard_command_sender dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .shift_flags (shift_flags),
        .delay_ms    (delay_ms),
        .rate_ms     (rate_ms),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tx_valid    (tx_valid),
        .tx_byte     (tx_byte),
        .done_res    (done_res),
        .status      (status),
        .enabled     (enabled)
    );

    kcs_command_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .shift_flags (shift_flags),
        .delay_ms    (delay_ms),
        .rate_ms     (rate_ms),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tx_valid    (tx_valid),
        .tx_byte     (tx_byte),
        .done_res    (done_res),
        .status      (status),
        .enabled     (enabled),
        .err_count   (err_count),
        .outstanding (outstanding),
        .seq_busy    (chk_busy),
        .cmds_on     (chk_cmds_on)
    );

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result receiver. The stall changes at the falling edge only. A long hold
    // keeps the output stalled so that the block fills and stalls its input.
    always @(negedge clk)
    begin
        if (hold_seen != hold_epoch)
        begin
            hold_seen <= hold_epoch;
            hold_left <= LONG_HOLD;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Watchdog: any transfer on any channel clears the count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Delays and rates lean on the points where the typematic codes change.
    function automatic logic [15:0] pick_delay();
        case ($urandom_range(0, 15))
            0:       return 16'd0;
            1:       return 16'd374;
            2:       return 16'd375;
            3:       return 16'd624;
            4:       return 16'd625;
            5:       return 16'd874;
            6:       return 16'd875;
            7:       return 16'hFFFF;
            8:       return 16'($urandom_range(0, 1000));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_rate();
        case ($urandom_range(0, 15))
            0:       return 16'd0;
            1:       return 16'd33;
            2:       return 16'd34;
            3:       return 16'd48;
            4:       return 16'd49;
            5:       return 16'd500;
            6:       return 16'd515;
            7:       return 16'd516;
            8:       return 16'hFFFF;
            9:       return 16'($urandom_range(30, 600));
            10:      return 16'($urandom_range(30, 600));
            default: return 16'($urandom);
        endcase
    endfunction

    // Offers one event and returns at the falling edge after its transfer.
    // The valid stays high on return so that back-to-back events need no
    // second assignment in one time step; idle gaps lower it first.
    task automatic push_event(input logic [1:0] kind, input logic [15:0] flags,
                              input logic [15:0] dly, input logic [15:0] rte,
                              input logic [7:0] rx);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        if (kind == REQ_LEDS || kind == REQ_RATE || chk_busy)
            item_count++;
        in_valid    <= 1'b1;
        req_type    <= kind;
        shift_flags <= flags;
        delay_ms    <= dly;
        rate_ms     <= rte;
        rx_byte     <= rx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic push_rand(input logic [1:0] kind, input logic [7:0] rx);
        push_event(kind, 16'($urandom), pick_delay(), pick_rate(), rx);
    endtask

    // Answers the request in flight until it ends. A well-formed answer never
    // exhausts the resend attempts, the other-byte limit or the reply timeout;
    // a risky one ignores those limits and so reaches the failure paths.
    task automatic answer_until_idle(input bit risky);
        int         resends;
        int         others;
        int         ticks;
        int         pick;
        logic [7:0] junk;
        resends = 0;
        others  = 0;
        ticks   = 0;
        while (chk_busy)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                push_rand(($urandom_range(0, 1) != 0) ? REQ_LEDS : REQ_RATE, 8'($urandom));
            else if (pick < 25 && (risky || resends < cur_resend))
            begin
                push_rand(REQ_REPLY, KB_RETRY);
                resends++;
                others = 0;
                ticks  = 0;
            end
            else if (pick < 40 && (risky || others + 1 < cur_other))
            begin
                do
                    junk = 8'($urandom);
                while (junk == KB_ACK || junk == KB_RETRY);
                push_rand(REQ_REPLY, junk);
                others++;
                ticks = 0;
            end
            else if (pick < 55 && (risky || ticks + 1 < cur_timeout))
            begin
                push_rand(REQ_TICK, 8'($urandom));
                ticks++;
            end
            else
            begin
                push_rand(REQ_REPLY, KB_ACK);
                resends = 0;
                others  = 0;
                ticks   = 0;
            end
        end
    endtask

    // Random requests until the item count reaches the target. LED requests are
    // always answered well-formed, since a failed one turns commands off for the
    // rest of the run; about half of the rate requests take the risky answers.
    task automatic run_random(input int target);
        int pick;
        bit led;
        while (item_count < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                push_rand((pick < 4) ? REQ_TICK : REQ_REPLY, 8'($urandom));
            else
            begin
                led = ($urandom_range(0, 1) != 0);
                push_rand(led ? REQ_LEDS : REQ_RATE, 8'($urandom));
                answer_until_idle(!led && pick < 50);
            end
        end
    endtask

    // Lowers the valid and waits until every predicted result has come out and
    // the block has had time to finish any event that gives no result.
    task automatic settle();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (6)
            @(negedge clk);
    endtask

    // Leaves the write valid high so that consecutive writes need no lowering.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic program_regs(input int timeout, input int resend, input int other);
        settle();
        write_reg(CFG_TIMEOUT, 16'(timeout));
        write_reg(CFG_RESEND_LIM, 16'(resend));
        write_reg(CFG_MAX_OTHER, 16'(other));
        cfg_valid   <= 1'b0;
        cur_timeout = timeout;
        cur_resend  = resend;
        cur_other   = other;
    endtask

    initial
    begin
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset register values. A tick and an ACK while
        // idle are ignored.
        push_rand(REQ_TICK, 8'h00);
        push_rand(REQ_REPLY, KB_ACK);

        // LED request with every shift flag set, including one resend of the
        // data byte; then one with all flags clear.
        push_event(REQ_LEDS, 16'hFFFF, 16'h0000, 16'h0000, 8'hFF);
        push_rand(REQ_REPLY, KB_ACK);
        push_rand(REQ_REPLY, KB_RETRY);
        push_rand(REQ_REPLY, KB_ACK);
        push_event(REQ_LEDS, 16'h0000, 16'hFFFF, 16'hFFFF, 8'h00);
        push_rand(REQ_REPLY, KB_ACK);
        push_rand(REQ_REPLY, KB_ACK);

        // Smallest delay and rate settings; both kinds of request are rejected while busy,
        // and a quiet tick and a stray byte give no result.
        push_event(REQ_RATE, 16'h0000, 16'd0, 16'd0, 8'h00);
        push_rand(REQ_LEDS, 8'h00);
        push_rand(REQ_RATE, 8'hFF);
        push_rand(REQ_TICK, 8'hFF);
        push_rand(REQ_REPLY, 8'h00);
        push_rand(REQ_REPLY, KB_ACK);
        push_rand(REQ_REPLY, KB_ACK);

        // Largest delay and rate, so both codes saturate.
        push_event(REQ_RATE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        push_rand(REQ_REPLY, KB_ACK);
        push_rand(REQ_REPLY, KB_ACK);

        // Resends exhaust the attempts on the command byte, the enable byte goes
        // out and is resent once, and its ACK ends the request as failed.
        push_event(REQ_RATE, 16'h0000, 16'd375, 16'd500, 8'h00);
        repeat (6)
            push_rand(REQ_REPLY, KB_RETRY);
        push_rand(REQ_REPLY, KB_ACK);

        run_random(240);

        // Low extremes: the first tick times out and no resend is allowed.
        program_regs(1, 0, 1);
        run_random(480);

        // High extremes, with the sender idling more than the receiver.
        send_idle_pct = 82;
        recv_idle_pct = 19;
        program_regs(16'hFFFF, 15, 4095);
        run_random(720);

        // Zero timeout and zero other-byte limit fail on the first tick or byte.
        program_regs(0, 2, 0);
        run_random(960);

        // No idling from here on. The receiver holds off while a request and a
        // burst of rejected requests keep the sender busy, so the input stalls.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_regs(3, 1, 3);
        hold_epoch <= hold_epoch + 1;
        push_rand(REQ_LEDS, 8'($urandom));
        repeat (12)
            push_rand(REQ_RATE, 8'($urandom));
        answer_until_idle(1'b0);
        run_random(1200);

        program_regs(5, 3, 2);
        run_random(1430);

        // An LED request that fails on both bytes turns commands off; every
        // later request is skipped and every reply or tick is ignored.
        push_rand(REQ_LEDS, 8'($urandom));
        while (chk_busy)
            push_rand(REQ_REPLY, KB_RETRY);
        repeat (20)
            push_rand(2'($urandom_range(0, 3)), 8'($urandom));

        settle();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
